[rtl/shh_pkg.sv]
// Package for the sampled hash histogram: shared constants and the back-end state type.
// Used by the front end, the back end, the top and the testbench; it depends on nothing else.
`default_nettype none

package shh_pkg;

  localparam int unsigned MaxIndexBitsDefault = 16;
  localparam int unsigned HashW = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ReadIdxW = 16;

  localparam logic [CfgIdxW-1:0] RegIndexBits = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSampleBits = 2'd1;

  localparam logic [CfgW-1:0] IndexBitsReset = 5'd16;
  localparam logic [CfgW-1:0] SampleBitsReset = 5'd8;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic OpCount = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle = 3'b010,
    StResult = 3'b100
  } back_state_e;

endpackage

`default_nettype wire

[rtl/shh_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the counter table is an instance of it.
`default_nettype none

module shh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/shh_queue.sv]
// Two-entry queue that decouples the classifying front end from the table update back end.
// Depends on nothing beyond its width parameter.
`default_nettype none

module shh_queue #(
  parameter int unsigned Width = 17
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [Width-1:0] head_o
);

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;

  assign full_o = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign head_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i || pop_i)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3)
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

[rtl/shh_front.sv]
// Front end: holds the configuration registers, accepts input transactions and
// turns each into a table index and a count flag. Depends on shh_pkg.
`default_nettype none

module shh_front
  import shh_pkg::*;
#(
  parameter int unsigned MaxIndexBits = MaxIndexBitsDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [CfgW-1:0]         cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    opcode_i,
  input  wire logic [HashW-1:0]        hash_value_i,
  input  wire logic [ReadIdxW-1:0]     read_index_i,
  input  wire logic                    q_full_i,
  input  wire logic                    clearing_i,
  output logic                         push_o,
  output logic [MaxIndexBits:0]        item_o
);

  localparam logic [CfgW-1:0] MaxBitsCfg = CfgW'(MaxIndexBits);

  logic [CfgW-1:0]         index_bits_q;
  logic [CfgW-1:0]         sample_bits_q;
  logic [CfgW-1:0]         eff_bits;
  logic [MaxIndexBits-1:0] idx_mask;
  logic [MaxIndexBits-1:0] idx;
  logic                    top_nonzero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= IndexBitsReset;
      sample_bits_q <= SampleBitsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegIndexBits: index_bits_q <= cfg_data_i;
        RegSampleBits: sample_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The index width is clamped into 1 .. MaxIndexBits.
  always_comb begin
    if (index_bits_q == '0) begin
      eff_bits = CfgW'(1);
    end else if (index_bits_q > MaxBitsCfg) begin
      eff_bits = MaxBitsCfg;
    end else begin
      eff_bits = index_bits_q;
    end
  end

  always_comb begin
    for (int k = 0; k < MaxIndexBits; k++) begin
      idx_mask[k] = (CfgW'(k) < eff_bits);
    end
  end

  // Bit k lies in the top sample_bits bits when 63 - k is below sample_bits.
  always_comb begin
    top_nonzero = 1'b0;
    for (int k = 0; k < HashW; k++) begin
      if ((6'(HashW - 1 - k) < {1'b0, sample_bits_q}) && hash_value_i[k]) begin
        top_nonzero = 1'b1;
      end
    end
  end

  always_comb begin
    if (opcode_i == OpRead) begin
      idx = MaxIndexBits'(read_index_i);
    end else begin
      idx = hash_value_i[MaxIndexBits-1:0] & idx_mask;
    end
  end

  assign in_stall_o = q_full_i || clearing_i;
  assign push_o = in_valid_i && !in_stall_o;
  assign item_o = {(opcode_i == OpCount) && !top_nonzero, idx};

endmodule

`default_nettype wire

[rtl/shh_back.sv]
// Back end: clears the counter table after reset, then reads one entry per transaction,
// writes it back updated for a count, and holds the result. Depends on shh_pkg.
`default_nettype none

module shh_back
  import shh_pkg::*;
#(
  parameter int unsigned MaxIndexBits = MaxIndexBitsDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_empty_i,
  input  wire logic [MaxIndexBits:0]   q_head_i,
  output logic                         pop_o,
  output logic                         clearing_o,
  output logic                         ram_we_o,
  output logic [MaxIndexBits-1:0]      ram_waddr_o,
  output logic [CountW-1:0]            ram_wdata_o,
  output logic                         ram_re_o,
  output logic [MaxIndexBits-1:0]      ram_raddr_o,
  input  wire logic [CountW-1:0]       ram_rdata_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         sampled_o,
  output logic [CountW-1:0]            entry_count_o,
  output logic [CountW-1:0]            peak_count_o
);

  back_state_e             state_q, state_d;
  logic [MaxIndexBits-1:0] clr_addr_q, clr_addr_d;
  logic [MaxIndexBits-1:0] addr_q;
  logic                    count_q;
  logic                    out_valid_q, out_valid_d;
  logic                    out_sampled_q;
  logic [CountW-1:0]       out_entry_q;
  logic [CountW-1:0]       peak_q, peak_d;
  logic [CountW-1:0]       inc_val;
  logic                    load_out;

  assign inc_val = (ram_rdata_i == CountMax) ? ram_rdata_i : ram_rdata_i + CountW'(1);

  assign pop_o = (state_q == StIdle) && !q_empty_i && (!out_valid_q || !out_stall_i);
  assign load_out = (state_q == StResult);
  assign clearing_o = (state_q == StClear);

  assign ram_re_o = pop_o;
  assign ram_raddr_o = q_head_i[MaxIndexBits-1:0];

  always_comb begin
    ram_we_o = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = inc_val;
    if (state_q == StClear) begin
      ram_we_o = 1'b1;
      ram_waddr_o = clr_addr_q;
      ram_wdata_o = '0;
    end else if (state_q == StResult) begin
      ram_we_o = count_q;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      StClear: begin
        clr_addr_d = clr_addr_q + MaxIndexBits'(1);
        if (&clr_addr_q) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (pop_o) begin
          state_d = StResult;
        end
      end
      StResult: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    peak_d = peak_q;
    if (load_out && count_q && (inc_val > peak_q)) begin
      peak_d = inc_val;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_addr_q <= '0;
      out_valid_q <= 1'b0;
      peak_q <= '0;
    end else begin
      state_q <= state_d;
      clr_addr_q <= clr_addr_d;
      out_valid_q <= out_valid_d;
      peak_q <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q <= q_head_i[MaxIndexBits-1:0];
      count_q <= q_head_i[MaxIndexBits];
    end
    if (load_out) begin
      out_sampled_q <= count_q;
      out_entry_q <= count_q ? inc_val : ram_rdata_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sampled_o = out_sampled_q;
  assign entry_count_o = out_entry_q;
  assign peak_count_o = peak_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing_o |-> !pop_o)
    else $error("transaction taken during table clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResult) |-> !out_valid_q || !$past(out_stall_i) || $past(pop_o))
    else $error("result loaded over a held result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) 1'b1 |=> peak_q >= $past(peak_q))
    else $error("peak count decreased");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == StResult) |=> out_valid_q)
    else $error("result not presented");

endmodule

`default_nettype wire

[rtl/sampled_hash_histogram_top.sv]
// Sampled hash histogram: a front end that classifies hashes, a two-entry queue,
// and a back end that updates the counter table. Depends on shh_pkg and all shh_ modules.
//
// Each transaction either counts a 64-bit hash (its low index_bits pick a 32-bit
// counter; it counts only when its top sample_bits are zero, and the counter
// saturates) or reads one counter back. Every transaction returns exactly one result
// with the entry value and the peak count since reset. The back end reads the table
// entry from its registered-read RAM when it takes a transaction and, for a count,
// writes it back in its result state; it takes no new transaction in that state.
// After reset the table is cleared one entry a cycle; input stays stalled until the
// clear is done, while configuration writes are taken.
`default_nettype none

module sampled_hash_histogram_top
  import shh_pkg::*;
#(
  parameter int unsigned MaxIndexBits = MaxIndexBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                opcode_i,
  input  wire logic [HashW-1:0]    hash_value_i,
  input  wire logic [ReadIdxW-1:0] read_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     sampled_o,
  output logic [CountW-1:0]        entry_count_o,
  output logic [CountW-1:0]        peak_count_o
);

  localparam int unsigned Depth = 1 << MaxIndexBits;

  logic                    push;
  logic [MaxIndexBits:0]   push_item;
  logic                    q_full;
  logic                    q_empty;
  logic                    pop;
  logic [MaxIndexBits:0]   q_head;
  logic                    clearing;
  logic                    ram_we;
  logic [MaxIndexBits-1:0] ram_waddr;
  logic [CountW-1:0]       ram_wdata;
  logic                    ram_re;
  logic [MaxIndexBits-1:0] ram_raddr;
  logic [CountW-1:0]       ram_rdata;

  shh_front #(
    .MaxIndexBits(MaxIndexBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .hash_value_i(hash_value_i),
    .read_index_i(read_index_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .push_o      (push),
    .item_o      (push_item)
  );

  shh_queue #(
    .Width(MaxIndexBits + 1)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_item),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  shh_back #(
    .MaxIndexBits(MaxIndexBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sampled_o    (sampled_o),
    .entry_count_o(entry_count_o),
    .peak_count_o (peak_count_o)
  );

  shh_ram #(
    .Width(CountW),
    .Depth(Depth),
    .AddrW(MaxIndexBits)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire

[verif/sampled_hash_histogram_tb.sv]
// Testbench for sampled_hash_histogram_top: directed and random count and read transactions,
// each result checked against a local model of the counter table and the running peak.
// Depends on shh_pkg and the sampled_hash_histogram_top RTL.
module testbench
  import shh_pkg::*;
;

  localparam int unsigned ClkPeriod = 20;
  localparam int unsigned WatchdogCycles = 400_000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned ReportLimit = 10;
  // Register indexes with no register behind them; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] RegSpareLow = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHigh = 2'd3;

  typedef struct packed {
    logic              sampled;
    logic [CountW-1:0] entry;
    logic [CountW-1:0] peak;
  } hist_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                opcode_i = OpCount;
  logic [HashW-1:0]    hash_value_i = '0;
  logic [ReadIdxW-1:0] read_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                sampled_o;
  logic [CountW-1:0]   entry_count_o;
  logic [CountW-1:0]   peak_count_o;

  // Local copy of the block state and its configuration.
  bit [CountW-1:0] tally_table [0:(1 << MaxIndexBitsDefault) - 1];
  bit [CountW-1:0] tally_peak = '0;
  bit [CfgW-1:0]   model_index_bits = IndexBitsReset;
  bit [CfgW-1:0]   model_sample_bits = SampleBitsReset;

  hist_result_t pending_results[$];
  int unsigned  fail_count = 0;
  bit           sender_idle_on = 1'b1;
  bit           receiver_idle_on = 1'b1;
  int           hold_req = 0;

  sampled_hash_histogram_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .hash_value_i  (hash_value_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sampled_o     (sampled_o),
    .entry_count_o (entry_count_o),
    .peak_count_o  (peak_count_o)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // Mask of the low hash bits that select a counter, with the width clamped to 1..16.
  function automatic logic [ReadIdxW-1:0] slot_mask();
    int unsigned width;
    width = model_index_bits;
    if (width < 1) width = 1;
    if (width > MaxIndexBitsDefault) width = MaxIndexBitsDefault;
    return ReadIdxW'((32'd1 << width) - 1);
  endfunction

  function automatic bit hash_sampled(logic [HashW-1:0] hash, bit [CfgW-1:0] top_bits);
    if (top_bits == 0) return 1'b1;
    return (hash >> (HashW - top_bits)) == '0;
  endfunction

  function automatic hist_result_t histogram_step(logic op, logic [HashW-1:0] hash,
                                                  logic [ReadIdxW-1:0] rd_slot);
    hist_result_t res;
    logic [ReadIdxW-1:0] slot;
    res.sampled = 1'b0;
    if (op == OpRead) begin
      res.entry = tally_table[rd_slot];
    end else begin
      slot = hash[ReadIdxW-1:0] & slot_mask();
      res.entry = tally_table[slot];
      if (hash_sampled(hash, model_sample_bits)) begin
        res.sampled = 1'b1;
        if (res.entry != CountMax) res.entry = res.entry + 1;
        tally_table[slot] = res.entry;
        if (res.entry > tally_peak) tally_peak = res.entry;
      end
    end
    res.peak = tally_peak;
    return res;
  endfunction

  function automatic void log_failure(string what, bit has_want, hist_result_t want,
                                      hist_result_t got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      if (has_want)
        $display(
          "%0t %s: expected sampled=%0d entry=%0d peak=%0d, got sampled=%0d entry=%0d peak=%0d",
          $realtime, what, want.sampled, want.entry, want.peak,
          got.sampled, got.entry, got.peak);
      else
        $display("%0t %s: got sampled=%0d entry=%0d peak=%0d",
                 $realtime, what, got.sampled, got.entry, got.peak);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    hist_result_t got;
    hist_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{sampled_o, entry_count_o, peak_count_o};
      if (pending_results.size() == 0) begin
        log_failure("result with no transaction pending", 1'b0, got, got);
      end else begin
        want = pending_results.pop_front();
        if (got.sampled !== want.sampled || got.entry !== want.entry ||
            got.peak !== want.peak)
          log_failure("result mismatch", 1'b1, want, got);
      end
    end
  end

  // Output backpressure: short random bursts, or one long hold-off on request.
  always begin : result_stall
    @(posedge clk_i);
    if (hold_req > 0) begin
      out_stall_i <= 1'b1;
      repeat (hold_req) @(posedge clk_i);
      out_stall_i <= 1'b0;
      hold_req <= 0;
    end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Valid stays high after a transaction; the next call either reuses it or drops it.
  task automatic send_item(input logic op, input logic [HashW-1:0] hash,
                           input logic [ReadIdxW-1:0] rd_slot);
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    hash_value_i <= hash;
    read_index_i <= rd_slot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(histogram_step(op, hash, rd_slot));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegIndexBits) model_index_bits = value;
    else if (idx == RegSampleBits) model_sample_bits = value;
  endtask

  // Half are sampled hashes on a few hot counters so the counts and the peak climb;
  // the rest are other sampled hashes, hashes just outside the sample window, raw noise and reads.
  task automatic send_random_item(input logic [ReadIdxW-1:0] hot [8]);
    logic [HashW-1:0]    hash;
    logic [ReadIdxW-1:0] rd_slot;
    int                  pick;
    hash = {$urandom, $urandom};
    rd_slot = ReadIdxW'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      if ($urandom_range(0, 1) == 1) rd_slot = hot[$urandom_range(0, 7)] & slot_mask();
      send_item(OpRead, hash, rd_slot);
    end else begin
      if (pick < 70) hash[ReadIdxW-1:0] = hot[$urandom_range(0, 7)];
      if (pick < 75) begin
        hash &= ({HashW{1'b1}} >> model_sample_bits);
      end else if (pick < 88 && model_sample_bits != 0) begin
        hash &= ({HashW{1'b1}} >> model_sample_bits);
        hash[HashW - model_sample_bits] = 1'b1;
      end
      send_item(OpCount, hash, rd_slot);
    end
  endtask

  task automatic fill_hot(output logic [ReadIdxW-1:0] hot [8]);
    foreach (hot[i]) hot[i] = ReadIdxW'($urandom_range(0, 65535));
  endtask

  task automatic test_reset_defaults();
    send_item(OpRead, '0, '0);
    send_item(OpCount, '0, '0);
    send_item(OpCount, {HashW{1'b1}}, {ReadIdxW{1'b1}});
    send_item(OpCount, 64'h00FF_FFFF_FFFF_FFFF, '0);
    send_item(OpCount, 64'h0100_0000_0000_FFFF, '0);
    send_item(OpRead, {HashW{1'b1}}, {ReadIdxW{1'b1}});
    send_item(OpRead, {HashW{1'b1}}, '0);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    // An index width of zero acts as one bit, and zero sample bits count everything.
    write_reg(RegIndexBits, '0);
    write_reg(RegSampleBits, '0);
    send_item(OpCount, {HashW{1'b1}}, '0);
    send_item(OpCount, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_item(OpRead, '0, 16'h0001);
    wait_drained();
    // Both registers at their top value: index clamps to 16 bits, 31 top bits must be zero.
    write_reg(RegIndexBits, {CfgW{1'b1}});
    write_reg(RegSampleBits, {CfgW{1'b1}});
    send_item(OpCount, 64'h0000_0001_FFFF_FFFF, '0);
    send_item(OpCount, 64'h0000_0002_0000_FFFF, '0);
    wait_drained();
    write_reg(RegSpareLow, {CfgW{1'b1}});
    write_reg(RegSpareHigh, '0);
    send_item(OpCount, 64'h0000_0000_8000_0001, '0);
    send_item(OpRead, '0, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [CfgW-1:0]     index_choice [9];
    logic [CfgW-1:0]     sample_choice [9];
    logic [ReadIdxW-1:0] hot [8];
    index_choice = '{5'd1, 5'd16, 5'd4, 5'd31, 5'd8, 5'd0, 5'd12, 5'd16, 5'd0};
    sample_choice = '{5'd0, 5'd16, 5'd3, 5'd31, 5'd1, 5'd20, 5'd8, 5'd0, 5'd0};
    index_choice[8] = CfgW'($urandom_range(0, 31));
    sample_choice[8] = CfgW'($urandom_range(0, 31));
    for (int phase = 0; phase < 9; phase++) begin
      wait_drained();
      write_reg(RegIndexBits, index_choice[phase]);
      write_reg(RegSampleBits, sample_choice[phase]);
      sender_idle_on = $urandom_range(0, 3) != 0;
      receiver_idle_on = $urandom_range(0, 3) != 0;
      fill_hot(hot);
      repeat (100) send_random_item(hot);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    logic [ReadIdxW-1:0] hot [8];
    write_reg(RegIndexBits, 5'd4);
    write_reg(RegSampleBits, 5'd2);
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    fill_hot(hot);
    hold_req <= 300;
    repeat (40) send_random_item(hot);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    logic [ReadIdxW-1:0] hot [8];
    write_reg(RegIndexBits, 5'd6);
    write_reg(RegSampleBits, 5'd1);
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    fill_hot(hot);
    repeat (210) send_random_item(hot);
    wait_drained();
  endtask

  initial begin : run_tests
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    test_back_to_back();
    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("sampled_hash_histogram_top test passed");
    end else begin
      $display("sampled_hash_histogram_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(WatchdogCycles * ClkPeriod);
    $display("sampled_hash_histogram_top test failed");
    $finish;
  end

endmodule
